// ===== rtl/stp_pkg.sv =====
// shared types and constants for the stego pixel extractor
package stp_pkg;

  localparam int PIX_W     = 8;
  localparam int CNT_W     = 20;
  localparam int CFG_W     = 11;
  localparam int BPP_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int BYTE_BITS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] cover_pixel;
    logic [PIX_W-1:0] stego_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] text_byte;
    logic [CNT_W-1:0] byte_count;
    logic             end_flag;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] image_rows;
    logic [CFG_W-1:0] image_cols;
    logic [CFG_W-1:0] grid_step;
    logic [BPP_W-1:0] bits_per_pixel;
  } cfg_t;

  typedef struct packed {
    logic      push0;
    logic      push1;
    out_item_t data0;
    out_item_t data1;
  } push_t;

endpackage

// ===== rtl/stp_extract_core.sv =====
// raster tracking, hiding pixel selection and byte assembly
module stp_extract_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  stp_pkg::in_item_t pix,
  input  stp_pkg::cfg_t    cfg,
  output stp_pkg::push_t   push
);
  import stp_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CW    = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;
  localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIM);

  logic [DIM_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [DIM_W-1:0] rph_r, rph_nxt, cph_r, cph_nxt;
  logic             first_r, first_nxt, halted_r, halted_nxt;
  logic [BPP_W-1:0] off_r, off_nxt;
  logic [PIX_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CW-1:0]    rows_c, cols_c, step_c, rph_inc, cph_inc;
  logic             sel, byte_ok, end_ok;
  logic [PIX_W-1:0] mask, diff, v, acc_new;
  logic [BPP_W:0]   off_sum;

  always_comb begin
    if (cfg.image_rows == '0) begin
      rows_c = CW'(1);
    end else if (CW'(cfg.image_rows) > MAX_DIM_C) begin
      rows_c = MAX_DIM_C;
    end else begin
      rows_c = CW'(cfg.image_rows);
    end
    if (cfg.image_cols == '0) begin
      cols_c = CW'(1);
    end else if (CW'(cfg.image_cols) > MAX_DIM_C) begin
      cols_c = MAX_DIM_C;
    end else begin
      cols_c = CW'(cfg.image_cols);
    end
    step_c  = CW'(cfg.grid_step);
    rph_inc = CW'(rph_r) + CW'(1);
    cph_inc = CW'(cph_r) + CW'(1);

    if (cfg.bits_per_pixel >= BPP_W'(BYTE_BITS)) begin
      mask = '1;
    end else begin
      mask = (PIX_W'(1) << cfg.bits_per_pixel) - PIX_W'(1);
    end
    diff    = pix.stego_pixel - pix.cover_pixel;
    v       = diff & mask;
    acc_new = acc_r | PIX_W'(v << off_r);
    off_sum = {1'b0, off_r} + {1'b0, cfg.bits_per_pixel};

    sel = (cfg.grid_step != '0) && (cfg.bits_per_pixel != '0) &&
          (CW'(rph_r) == step_c - CW'(1)) && (CW'(cph_r) == step_c - CW'(1));

    row_nxt    = row_r;
    col_nxt    = col_r;
    rph_nxt    = rph_r;
    cph_nxt    = cph_r;
    first_nxt  = first_r;
    halted_nxt = halted_r;
    off_nxt    = off_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    byte_ok    = 1'b0;
    end_ok     = 1'b0;

    if (sel && !halted_r) begin
      if (!first_r) begin
        first_nxt = 1'b1;
      end else if (off_sum > (BPP_W+1)'(BYTE_BITS)) begin
        halted_nxt = 1'b1;
      end else if (off_sum == (BPP_W+1)'(BYTE_BITS)) begin
        if (acc_new != '0) begin
          byte_ok = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          acc_nxt = '0;
          off_nxt = '0;
        end else begin
          acc_nxt    = acc_new;
          off_nxt    = off_sum[BPP_W-1:0];
          halted_nxt = 1'b1;
        end
      end else begin
        acc_nxt = acc_new;
        off_nxt = off_sum[BPP_W-1:0];
      end
    end

    // end of row / end of image
    if (CW'(col_r) + CW'(1) >= cols_c) begin
      if (CW'(row_r) + CW'(1) >= rows_c) begin
        end_ok = 1'b1;
      end else begin
        col_nxt = '0;
        cph_nxt = '0;
        row_nxt = row_r + DIM_W'(1);
        if (step_c == '0 || rph_inc >= step_c) begin
          rph_nxt = '0;
        end else begin
          rph_nxt = rph_inc[DIM_W-1:0];
        end
      end
    end else begin
      col_nxt = col_r + DIM_W'(1);
      if (step_c == '0 || cph_inc >= step_c) begin
        cph_nxt = '0;
      end else begin
        cph_nxt = cph_inc[DIM_W-1:0];
      end
    end

    push.data1.text_byte  = '0;
    push.data1.byte_count = cnt_nxt;
    push.data1.end_flag   = 1'b1;
    if (byte_ok) begin
      push.data0.text_byte  = acc_new;
      push.data0.byte_count = cnt_r;
      push.data0.end_flag   = 1'b0;
    end else begin
      push.data0 = push.data1;
    end
    push.push0 = fire && (byte_ok || end_ok);
    push.push1 = fire && byte_ok && end_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      rph_r    <= '0;
      cph_r    <= '0;
      first_r  <= 1'b0;
      halted_r <= 1'b0;
      off_r    <= '0;
      acc_r    <= '0;
      cnt_r    <= '0;
    end else if (fire) begin
      if (end_ok) begin
        row_r    <= '0;
        col_r    <= '0;
        rph_r    <= '0;
        cph_r    <= '0;
        first_r  <= 1'b0;
        halted_r <= 1'b0;
        off_r    <= '0;
        acc_r    <= '0;
        cnt_r    <= '0;
      end else begin
        row_r    <= row_nxt;
        col_r    <= col_nxt;
        rph_r    <= rph_nxt;
        cph_r    <= cph_nxt;
        first_r  <= first_nxt;
        halted_r <= halted_nxt;
        off_r    <= off_nxt;
        acc_r    <= acc_nxt;
        cnt_r    <= cnt_nxt;
      end
    end
  end

endmodule

// ===== rtl/stp_out_fifo.sv =====
// four entry result queue taking up to two results per cycle
module stp_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  stp_pkg::push_t     push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output stp_pkg::out_item_t out_data
);
  import stp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  out_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= (PTR_W+1)'(DEPTH - 2));

  always_comb begin
    wr_nxt    = wr_r + PTR_W'(push.push0) + PTR_W'(push.push1);
    rd_nxt    = rd_r + PTR_W'(pop);
    count_nxt = count_r + (PTR_W+1)'(push.push0) + (PTR_W+1)'(push.push1)
              - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_r] <= push.data0;
    end
    if (push.push1) begin
      mem_r[wr_r + PTR_W'(1)] <= push.data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/stego_pixel_extract.sv =====
// top level: input register, config registers, extraction core, result queue
// an input transfer passes through the input register and then the result queue on its way to out_valid
// throughput: one pixel pair per cycle while the result queue has room, set by the single compute stage
// a pixel that ends the image and completes a byte gives two results in one cycle,
// absorbed by the four entry result queue
// reset (synchronous, rst_n low) clears counters and queue, sets all config registers to 1
module stego_pixel_extract #(
  parameter int MAX_DIM = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  stp_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output stp_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [stp_pkg::CFG_W-1:0]    cfg_wdata
);
  import stp_pkg::*;

  cfg_t     cfg_r;
  logic     s1_valid_r;
  in_item_t s1_data_r;
  logic     room, adv;
  push_t    push;

  assign adv      = s1_valid_r && room;
  assign in_ready = !s1_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_rows     <= CFG_W'(1);
      cfg_r.image_cols     <= CFG_W'(1);
      cfg_r.grid_step      <= CFG_W'(1);
      cfg_r.bits_per_pixel <= BPP_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_ROWS:     cfg_r.image_rows     <= cfg_wdata;
        REG_IMAGE_COLS:     cfg_r.image_cols     <= cfg_wdata;
        REG_GRID_STEP:      cfg_r.grid_step      <= cfg_wdata;
        REG_BITS_PER_PIXEL: cfg_r.bits_per_pixel <= cfg_wdata[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  stp_extract_core #(
    .MAX_DIM(MAX_DIM)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (adv),
    .pix  (s1_data_r),
    .cfg  (cfg_r),
    .push (push)
  );

  stp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // a stalled pixel stays in the input register
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !room |=> s1_valid_r && $stable(s1_data_r))
    else $error("stalled input register lost its pixel");

  // second result of a pixel is always the count, behind a byte
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0 && push.data1.end_flag && !push.data0.end_flag)
    else $error("bad ordering of two results from one pixel");

  // count results carry no text
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_flag |-> out_data.text_byte == '0)
    else $error("count result with nonzero text byte");

endmodule
